FILE: rtl/core/sltd_pkg.sv
// ----------------------------------------------------------------------------
// sltd_pkg: shared types and constants of the sorted level tick dispatcher
// Command and result formats, status and kind codes, and the entry layout
// used by the front and back parts of the dispatcher.
// ----------------------------------------------------------------------------
package sltd_pkg;

	// Default size of the level table.
	localparam int MAX_LEVELS_DEF = 16;

	// Depth of the command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Field widths.
	localparam int LEVEL_W  = 8;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 2;
	localparam int OUT_DATA_W = 16;

	// Operation codes of an input request.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Kind codes of a result.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// Countdown value at which an entry is due, and the start value of a new entry.
	localparam logic [COUNT_W-1:0] DUE_COUNT  = 16'd1;
	localparam logic [COUNT_W-1:0] START_COUNT = 16'd1;

	// Outcome of an insert.
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_FULL     = 2'd2
	} ins_status_t;

	// Classified command handed from the front part to the back part.
	typedef struct packed {
		logic               is_tick;
		logic [LEVEL_W-1:0] key;
	} cmd_t;

	// Queue channel towards the back part.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qchan_t;

	// One result request.
	typedef struct packed {
		logic               kind;
		ins_status_t        status;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} result_t;

	// One table entry.
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [COUNT_W-1:0] countdown;
		logic [COUNT_W-1:0] period;
	} entry_t;

endpackage

FILE: rtl/core/sltd_front.sv
// ----------------------------------------------------------------------------
// sltd_front: request intake and command queue
// Accepts input requests, classifies them into insert or tick commands and
// holds them in a short queue that the back part drains at its own pace.
// ----------------------------------------------------------------------------
module sltd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_op,
	input  logic [sltd_pkg::LEVEL_W-1:0]    in_key,
	output sltd_pkg::qchan_t                q_out,
	input  logic                            q_ready
);

	localparam int PW   = (sltd_pkg::QUEUE_DEPTH > 1) ? $clog2(sltd_pkg::QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(sltd_pkg::QUEUE_DEPTH + 1);

	sltd_pkg::cmd_t   mem_q [sltd_pkg::QUEUE_DEPTH];
	sltd_pkg::cmd_t   cmd_in;
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  fill_q;
	logic             push;
	logic             pop;

	// Classify the incoming request.
	always_comb begin
		cmd_in.is_tick = (in_op == sltd_pkg::OP_TICK);
		cmd_in.key     = in_key;
	end

	assign in_ready      = (fill_q != CNTW'(sltd_pkg::QUEUE_DEPTH));
	assign push          = in_valid && in_ready;
	assign q_out.valid   = (fill_q != '0);
	assign q_out.cmd     = mem_q[rd_ptr_q];
	assign pop           = q_out.valid && q_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PW'(sltd_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PW'(1);
				end
			end
			if (pop) begin
				if (rd_ptr_q == PW'(sltd_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PW'(1);
				end
			end
			case ({push, pop})
				2'b10: begin
					fill_q <= fill_q + CNTW'(1);
				end
				2'b01: begin
					fill_q <= fill_q - CNTW'(1);
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/sltd_back.sv
// ----------------------------------------------------------------------------
// sltd_back: level table and command sequencer
// Keeps the sorted level table as a row of cells, carries out insert and tick
// commands and drives the result output register.
// ----------------------------------------------------------------------------
module sltd_back #(
	parameter int MAX_LEVELS = sltd_pkg::MAX_LEVELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sltd_pkg::qchan_t                       q_in,
	output logic                                   q_ready,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output sltd_pkg::result_t                      out_res,
	output logic [$clog2(MAX_LEVELS + 1)-1:0]      entry_count,
	output logic                                   idle
);

	localparam int CW = $clog2(MAX_LEVELS + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CMP   = 5'b00010,
		S_WR    = 5'b00100,
		S_TICK  = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	sltd_pkg::entry_t                ent_q [MAX_LEVELS];
	sltd_pkg::entry_t                upd0;
	sltd_pkg::entry_t                new_ent;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   step_q;
	logic [sltd_pkg::LEVEL_W-1:0]    key_q;
	logic [sltd_pkg::LEVEL_W-1:0]    pend_lvl_q;
	logic                            pend_q;
	logic                            dup_q;
	logic [MAX_LEVELS-1:0]           gt_q;
	logic [MAX_LEVELS-1:0]           eq_c;
	logic [MAX_LEVELS-1:0]           gt_c;
	logic                            out_v_q;
	sltd_pkg::result_t               out_res_q;
	sltd_pkg::result_t               push_res;
	sltd_pkg::ins_status_t           ins_st;
	logic                            push_v;
	logic                            ins_wr;
	logic                            rot_en;
	logic                            out_free;
	logic                            due0;

	assign out_free    = !out_v_q || out_ready;
	assign out_valid   = out_v_q;
	assign out_res     = out_res_q;
	assign entry_count = count_q;
	assign idle        = (state_q == S_IDLE);

	// Compare every live cell with the key of the pending insert.
	always_comb begin
		for (int i = 0; i < MAX_LEVELS; i++) begin
			eq_c[i] = (CW'(i) < count_q) && (ent_q[i].level == key_q);
			gt_c[i] = (CW'(i) < count_q) && (ent_q[i].level > key_q);
		end
	end

	// Outcome of the insert once the compare flags are registered.
	always_comb begin
		if (dup_q) begin
			ins_st = sltd_pkg::ST_PRESENT;
		end else if (count_q == CW'(MAX_LEVELS)) begin
			ins_st = sltd_pkg::ST_FULL;
		end else begin
			ins_st = sltd_pkg::ST_INSERTED;
		end
	end

	// Head cell as it leaves for the back of the row during a tick.
	always_comb begin
		due0             = (ent_q[0].countdown == sltd_pkg::DUE_COUNT);
		upd0.level       = ent_q[0].level;
		upd0.period      = ent_q[0].period;
		upd0.countdown   = due0 ? ent_q[0].period
			: ent_q[0].countdown - sltd_pkg::COUNT_W'(1);
		new_ent.level     = key_q;
		new_ent.countdown = sltd_pkg::START_COUNT;
		new_ent.period    = sltd_pkg::START_COUNT;
	end

	// Sequencer.
	always_comb begin
		state_d         = state_q;
		q_ready         = 1'b0;
		push_v          = 1'b0;
		ins_wr          = 1'b0;
		rot_en          = 1'b0;
		push_res.kind   = sltd_pkg::KIND_INSERT;
		push_res.status = ins_st;
		push_res.level  = key_q;
		push_res.last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				q_ready = 1'b1;
				if (q_in.valid) begin
					if (q_in.cmd.is_tick) begin
						if (count_q != '0) begin
							state_d = S_TICK;
						end
					end else begin
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				state_d = S_WR;
			end
			S_WR: begin
				if (out_free) begin
					push_v  = 1'b1;
					ins_wr  = (ins_st == sltd_pkg::ST_INSERTED);
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				push_res.kind   = sltd_pkg::KIND_TICK;
				push_res.status = sltd_pkg::ST_INSERTED;
				push_res.level  = pend_lvl_q;
				push_res.last   = 1'b0;
				if (!(due0 && pend_q && !out_free)) begin
					rot_en = 1'b1;
					push_v = due0 && pend_q;
					if (step_q == count_q - CW'(1)) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				push_res.kind   = sltd_pkg::KIND_TICK;
				push_res.status = sltd_pkg::ST_INSERTED;
				push_res.level  = pend_lvl_q;
				push_res.last   = 1'b1;
				if (!pend_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					push_v  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			pend_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				step_q <= '0;
				pend_q <= 1'b0;
			end
			if (ins_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (rot_en) begin
				step_q <= step_q + CW'(1);
				if (due0) begin
					pend_q <= 1'b1;
				end
			end
			if (out_free) begin
				out_v_q <= push_v;
			end
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_in.valid) begin
			key_q <= q_in.cmd.key;
		end
		if (state_q == S_CMP) begin
			gt_q  <= gt_c;
			dup_q <= |eq_c;
		end
		if (rot_en && due0) begin
			pend_lvl_q <= ent_q[0].level;
		end
		if (out_free && push_v) begin
			out_res_q <= push_res;
		end
	end

	// Row of cells: an insert opens a gap by moving larger levels up one place,
	// a tick rotates the live cells down by one with the head going to the back.
	for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
		sltd_pkg::entry_t up_ent;
		sltd_pkg::entry_t dn_ent;
		logic             dn_gt;
		logic             sel;

		if (g < MAX_LEVELS - 1) begin : g_up
			assign up_ent = ent_q[g + 1];
		end else begin : g_top
			assign up_ent = upd0;
		end

		if (g > 0) begin : g_dn
			assign dn_ent = ent_q[g - 1];
			assign dn_gt  = gt_q[g - 1];
		end else begin : g_bottom
			assign dn_ent = new_ent;
			assign dn_gt  = 1'b0;
		end

		assign sel = ((CW'(g) < count_q) && gt_q[g]) || (CW'(g) == count_q);

		always_ff @(posedge clk) begin
			if (ins_wr && sel) begin
				ent_q[g] <= dn_gt ? dn_ent : new_ent;
			end else if (rot_en) begin
				if (CW'(g + 1) == count_q) begin
					ent_q[g] <= upd0;
				end else if (CW'(g + 1) < count_q) begin
					ent_q[g] <= up_ent;
				end
			end
		end
	end

endmodule

FILE: rtl/core/sorted_level_tick_dispatcher.sv
// ----------------------------------------------------------------------------
// sorted_level_tick_dispatcher: periodic priority-level scheduler
// Keeps a sorted table of task levels and dispatches them on every tick.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per transfer: tuser selects an insert
// (0) or a tick (1), tdata[7:0] carries the level of an insert. The master
// stream returns results: tuser is 0 for an insert status and 1 for a
// dispatched level, tdata holds the status and the level, and tlast marks
// the final result caused by one request.
// An insert holds the back part through its compare and write states and
// presents its one result from the output register. A tick walks the stored
// entries in ascending order, one entry per cycle while the receiver keeps up,
// rotating the single head cell of the entry row to the back each time.
// A tick on an empty table gives no result.
// A two-request queue lets the intake keep taking requests while the back
// part works. When the receiver stalls, the result waits in the output
// register and the back part holds; the table is left intact.
// Reset empties the table and the queue and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_level_tick_dispatcher #(
	parameter int MAX_LEVELS = sltd_pkg::MAX_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] level_key
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [1:0] insert_status, [9:2] run_level, [15:10] zero
	output logic        m_axis_tuser,   // [0] result_kind
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(MAX_LEVELS + 1);

	sltd_pkg::qchan_t  qchan;
	sltd_pkg::result_t res;
	logic              q_ready;
	logic [CW-1:0]     entry_count;
	logic              back_idle;

	// Intake and command queue.
	sltd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_key   (s_axis_tdata),
		.q_out    (qchan),
		.q_ready  (q_ready)
	);

	// Level table and sequencer.
	sltd_back #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_in        (qchan),
		.q_ready     (q_ready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res),
		.entry_count (entry_count),
		.idle        (back_idle)
	);

	// Pack the result onto the master stream.
	assign m_axis_tdata = {{(sltd_pkg::OUT_DATA_W - sltd_pkg::LEVEL_W - sltd_pkg::STATUS_W){1'b0}},
		res.level, res.status};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

`ifndef SYNTH
	// The table never holds more entries than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CW'(MAX_LEVELS))
		else $error("level table over-filled");

	// The table only grows, by one entry, and only while a command is in work.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(entry_count) |->
			(entry_count == $past(entry_count) + CW'(1)) && !$past(back_idle))
		else $error("level table count changed unexpectedly");

	// A dispatch result always carries a zero status.
	a_tick_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == sltd_pkg::KIND_TICK)) |->
			(m_axis_tdata[1:0] == sltd_pkg::ST_INSERTED))
		else $error("dispatch result with non-zero status");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted level tick dispatcher
// Feeds insert and tick requests over the slave stream, predicts the sorted
// level table and every dispatch in the bench, and compares each result
// request on the master stream field by field. Both streams idle at random,
// and the receiver holds off once for a long stretch to fill the block up.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int TABLE_SIZE      = sltd_pkg::MAX_LEVELS_DEF;
	localparam int RANDOM_REQUESTS = 315;
	localparam int IDLE_PCT        = 6;
	localparam int QUIET_FROM      = 60;
	localparam int QUIET_TO        = 130;
	localparam int STALL_AT        = 200;
	localparam int STALL_CYCLES    = 300;
	localparam int DRAIN_CYCLES    = 64;
	localparam int CYCLE_LIMIT     = 500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] level_key
	logic        s_axis_tuser = 1'b0; // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [1:0] insert_status, [9:2] run_level, [15:10] zero
	logic        m_axis_tuser;        // [0] result_kind
	logic        m_axis_tlast;

	// Requests waiting to be offered, and results still owed by the block.
	sltd_pkg::cmd_t    request_backlog[$];
	sltd_pkg::result_t awaited_results[$];

	// Predicted state of the level table.
	sltd_pkg::entry_t level_table[TABLE_SIZE];
	int               levels_stored = 0;

	// Levels the stimulus has already placed in the table.
	bit         key_seen[256];
	logic [7:0] held_keys[$];

	int cycle_count     = 0;
	int requests_sent   = 0;
	int results_seen    = 0;
	int dispatches_seen = 0;
	int present_seen    = 0;
	int full_seen       = 0;
	int mismatches      = 0;
	int stall_left      = 0;
	bit stall_done      = 1'b0;

	sorted_level_tick_dispatcher u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	// Both sides stop idling for a while once this many requests have gone in.
	function automatic bit quiet_window();
		return requests_sent >= QUIET_FROM && requests_sent < QUIET_TO;
	endfunction

	// Applies one accepted request to the predicted table and queues the
	// results it must produce.
	task automatic advance_schedule(input logic op, input logic [sltd_pkg::LEVEL_W-1:0] key);
		sltd_pkg::result_t res;
		sltd_pkg::result_t prev;
		sltd_pkg::entry_t  tmp;
		bit                found;
		bit                have_prev;
		int                slot;
		found = 1'b0;
		have_prev = 1'b0;
		if (op == sltd_pkg::OP_INSERT) begin
			res.kind  = sltd_pkg::KIND_INSERT;
			res.level = key;
			res.last  = 1'b1;
			for (int i = 0; i < levels_stored; i++) begin
				if (level_table[i].level == key)
					found = 1'b1;
			end
			// The duplicate check takes precedence over a full table.
			if (found) begin
				res.status = sltd_pkg::ST_PRESENT;
			end else if (levels_stored >= TABLE_SIZE) begin
				res.status = sltd_pkg::ST_FULL;
			end else begin
				slot = levels_stored;
				level_table[slot] = '{level: key, countdown: sltd_pkg::START_COUNT,
					period: sltd_pkg::START_COUNT};
				levels_stored++;
				// Sift the new level towards the front while it is smaller.
				while (slot > 0 && level_table[slot].level < level_table[slot-1].level) begin
					tmp = level_table[slot];
					level_table[slot] = level_table[slot-1];
					level_table[slot-1] = tmp;
					slot--;
				end
				res.status = sltd_pkg::ST_INSERTED;
			end
			awaited_results.push_back(res);
		end else begin
			// Walk the table in ascending order; the final dispatch carries last.
			for (int i = 0; i < levels_stored; i++) begin
				if (level_table[i].countdown == sltd_pkg::DUE_COUNT) begin
					level_table[i].countdown = level_table[i].period;
					if (have_prev)
						awaited_results.push_back(prev);
					prev = '{kind: sltd_pkg::KIND_TICK, status: sltd_pkg::ST_INSERTED,
						level: level_table[i].level, last: 1'b0};
					have_prev = 1'b1;
				end else begin
					level_table[i].countdown = level_table[i].countdown
						- sltd_pkg::COUNT_W'(1);
				end
			end
			if (have_prev) begin
				prev.last = 1'b1;
				awaited_results.push_back(prev);
			end
		end
	endtask

	// Adds a request to the backlog and tracks which levels it will store.
	task automatic queue_request(input logic op, input logic [7:0] key);
		request_backlog.push_back('{is_tick: op, key: key});
		if (op == sltd_pkg::OP_INSERT && !key_seen[key] && held_keys.size() < TABLE_SIZE) begin
			key_seen[key] = 1'b1;
			held_keys.push_back(key);
		end
	endtask

	task automatic report_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// Request driver: holds a request until it is taken, then offers the next.
	always @(posedge clk) begin : request_driver
		sltd_pkg::cmd_t req;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_schedule(s_axis_tuser, s_axis_tdata);
				requests_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (request_backlog.size() != 0
						&& (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
					req = request_backlog.pop_front();
					s_axis_tuser  <= req.is_tick;
					s_axis_tdata  <= req.key;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random back-pressure plus one long hold-off.
	always @(posedge clk) begin : result_receiver
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!stall_done && requests_sent >= STALL_AT) begin
				stall_left    <= STALL_CYCLES;
				stall_done    <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Result monitor: each accepted result is checked against the oldest
	// prediction.
	always @(posedge clk) begin : result_monitor
		sltd_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b tlast=%b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				want = awaited_results.pop_front();
				report_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
				report_field("insert_status", 32'(want.status), 32'(m_axis_tdata[1:0]));
				report_field("run_level", 32'(want.level), 32'(m_axis_tdata[9:2]));
				report_field("last", 32'(want.last), 32'(m_axis_tlast));
				report_field("tdata padding", 0, 32'(m_axis_tdata[15:10]));
				if (want.kind == sltd_pkg::KIND_TICK)
					dispatches_seen++;
				else if (want.status == sltd_pkg::ST_PRESENT)
					present_seen++;
				else if (want.status == sltd_pkg::ST_FULL)
					full_seen++;
			end
		end
	end

	// Watchdog on the overall run length.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
		$display("** sorted_level_tick_dispatcher: FAILED **");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		// Directed part: empty table, field extremes, duplicates and sorting.
		queue_request(sltd_pkg::OP_TICK, 8'hA5);
		queue_request(sltd_pkg::OP_INSERT, 8'hFF);
		queue_request(sltd_pkg::OP_INSERT, 8'h00);
		queue_request(sltd_pkg::OP_INSERT, 8'h00);
		queue_request(sltd_pkg::OP_TICK, 8'h00);
		queue_request(sltd_pkg::OP_INSERT, 8'h80);
		queue_request(sltd_pkg::OP_INSERT, 8'h7F);
		queue_request(sltd_pkg::OP_INSERT, 8'h01);
		queue_request(sltd_pkg::OP_INSERT, 8'hFE);
		queue_request(sltd_pkg::OP_TICK, 8'h5A);
		queue_request(sltd_pkg::OP_INSERT, 8'hFF);
		queue_request(sltd_pkg::OP_INSERT, 8'h40);
		queue_request(sltd_pkg::OP_TICK, 8'hFF);

		// Random part: ticks mixed with fresh and repeated levels; the table
		// fills up along the way and later inserts meet a full table.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if ($urandom_range(1) == 1)
				queue_request(sltd_pkg::OP_TICK, 8'($urandom_range(255)));
			else if (held_keys.size() != 0 && $urandom_range(99) < 30)
				queue_request(sltd_pkg::OP_INSERT,
					held_keys[$urandom_range(held_keys.size() - 1)]);
			else
				queue_request(sltd_pkg::OP_INSERT, 8'($urandom_range(255)));
		end

		// Make sure the table ends full, then try a new level and a duplicate.
		for (int k = 0; k < 256 && held_keys.size() < TABLE_SIZE; k++) begin
			if (!key_seen[k])
				queue_request(sltd_pkg::OP_INSERT, 8'(k));
		end
		for (int k = 255; k >= 0; k--) begin
			if (!key_seen[k]) begin
				queue_request(sltd_pkg::OP_INSERT, 8'(k));
				break;
			end
		end
		queue_request(sltd_pkg::OP_INSERT, held_keys[0]);
		queue_request(sltd_pkg::OP_TICK, 8'h3C);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d results: %0d dispatched levels,",
			requests_sent, results_seen, dispatches_seen);
		$display("%0d duplicate inserts and %0d inserts refused on a full table.",
			present_seen, full_seen);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("** sorted_level_tick_dispatcher: PASSED **");
		end else begin
			$display("** sorted_level_tick_dispatcher: FAILED **");
		end
		$finish;
	end

endmodule
